>>> hdl/dbc_pkg.sv
package dbc_pkg;

	localparam int DEF_NUM_CHANNELS       = 2;
	localparam int DEF_SAMPLE_BITS        = 24;
	localparam int DEF_COEF_FRAC_BITS     = 28;
	localparam int DEF_TANH_TABLE_ENTRIES = 1024;

	// fraction bits kept below the sample LSB in the delay words
	localparam int GUARD_BITS = 8;

	localparam int COEF_W     = 32;
	localparam int DRIVE_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [DRIVE_W-1:0] DRIVE_ONE   = 16'd32768;
	localparam logic [COEF_W-1:0]  COEF_B0_RST = 32'd268435456;

	localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TWO    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 3'd7;

	// unsigned quotient by shift and subtract; divisor stays below 2^63
	function automatic longint unsigned udiv64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(4*idx/entries) in sample scale, integer build: e^-a by series in Q30,
	// raised to the 16th power by four rounded squarings, then (1-e)/(1+e).
	// Only evaluated at elaboration to fill the shaper table.
	function automatic longint unsigned tanh_entry(input int unsigned idx,
			input int unsigned entries, input int unsigned sbits);
		longint unsigned q30;
		longint unsigned a;
		longint unsigned term;
		longint unsigned e;
		longint unsigned num;
		longint unsigned den;
		longint sum;
		q30 = 64'd1 << 30;
		a = udiv64(64'(idx) << 29, 64'(entries));
		sum = longint'(q30);
		term = q30;
		for (int unsigned k = 1; k <= 12; k++) begin
			term = udiv64((term * a) >> 30, 64'(k));
			if (k[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		e = (sum > 0) ? longint'(sum) : 64'd0;
		for (int r = 0; r < 4; r++)
			e = (e * e + (64'd1 << 29)) >> 30;
		if (e > q30)
			e = q30;
		num = q30 - e;
		den = q30 + e;
		return udiv64((num << (sbits - 1)) + (den >> 1), den);
	endfunction

endpackage

>>> hdl/drive_biquad_cascade_unit.sv
// Each request runs states S0 to S5 once per biquad section, after the tanh shaper
//   states when drive is active; bypass and absent channels go straight to DONE.
//   A new request is taken only in IDLE, after DONE has handed on the last result;
//   all multiplies share one registered multiplier and the delay words one state memory.
// Reset (arst_n low, async): registers return to defaults, state memory reads as zero
//   through per-entry valid bits, no clearing pass.
module drive_biquad_cascade_unit #(
	parameter int NUM_CHANNELS       = dbc_pkg::DEF_NUM_CHANNELS,
	parameter int SAMPLE_BITS        = dbc_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS     = dbc_pkg::DEF_COEF_FRAC_BITS,
	parameter int TANH_TABLE_ENTRIES = dbc_pkg::DEF_TANH_TABLE_ENTRIES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [SAMPLE_BITS-1:0] sample_in, rest zero
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
	// [0] channel_in
	input  logic                                   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [SAMPLE_BITS-1:0] sample_out, rest zero
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
	// [0] channel_out
	output logic                                   m_axis_tuser,
	input  logic                                   cfg_we,
	input  logic [dbc_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic [dbc_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

	import dbc_pkg::*;

	localparam int SB        = SAMPLE_BITS;
	localparam int NT        = TANH_TABLE_ENTRIES;
	localparam int TD_W      = ((SB + 7) / 8) * 8;
	localparam int STW       = SB + 16;
	localparam int A_W       = COEF_W + 1;
	localparam int B_W       = SB + 1;
	localparam int PRW       = A_W + B_W;
	localparam int MG_W      = SB + 17;
	localparam int RA_W      = $clog2(NT + 1);
	localparam int SH        = SB + 16;
	localparam int PW        = MG_W + RA_W;
	localparam int MEM_DEPTH = 4 * NUM_CHANNELS;
	localparam int MA_W      = $clog2(MEM_DEPTH);
	localparam int RS        = COEF_FRAC_BITS - GUARD_BITS;

	localparam logic signed [PRW-1:0] RS_HALF = PRW'(1) <<< (RS - 1);
	localparam logic signed [PRW-1:0] G_HALF  = PRW'(1) <<< (GUARD_BITS - 1);
	localparam logic signed [PRW-1:0] Y_MAX   = PRW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [PRW-1:0] Y_MIN   = -Y_MAX - PRW'(1);
	localparam logic signed [PRW-1:0] S_MAX   = PRW'((64'sd1 <<< (STW - 1)) - 64'sd1);
	localparam logic signed [PRW-1:0] S_MIN   = -S_MAX - PRW'(1);

	typedef logic [SB-1:0] rom_t [0:NT];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i <= NT; i++)
			r[i] = SB'(tanh_entry(i, NT, SB));
		return r;
	endfunction

	localparam rom_t TANH_ROM = build_rom();

	function automatic logic signed [PRW-1:0] rnd_coef(input logic signed [PRW-1:0] v);
		return (v + RS_HALF) >>> RS;
	endfunction

	function automatic logic signed [SB-1:0] sat_y(input logic signed [PRW-1:0] v);
		logic signed [PRW-1:0] c;
		c = (v > Y_MAX) ? Y_MAX : ((v < Y_MIN) ? Y_MIN : v);
		return c[SB-1:0];
	endfunction

	function automatic logic signed [STW-1:0] sat_st(input logic signed [PRW-1:0] v);
		logic signed [PRW-1:0] c;
		c = (v > S_MAX) ? S_MAX : ((v < S_MIN) ? S_MIN : v);
		return c[STW-1:0];
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SH_MUL,
		ST_SH_IDX,
		ST_SH_RLO,
		ST_SH_RHI,
		ST_SH_DIF,
		ST_SH_T,
		ST_S0,
		ST_S1,
		ST_S2,
		ST_S3,
		ST_S4,
		ST_S5,
		ST_DONE
	} state_t;

	state_t state_q;

	logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [DRIVE_W-1:0]       drive_q;
	logic                     two_q;
	logic                     bypass_q;

	logic signed [SB-1:0]     x_q;
	logic signed [SB-1:0]     y_q;
	logic                     ch_q;
	logic                     st_q;
	logic signed [PRW-1:0]    acc_q;
	logic [RA_W-1:0]          idx_q;
	logic                     end_q;
	logic [23:0]              frac_q;
	logic [SB-1:0]            lo_q;
	logic                     out_valid_q;
	logic [SB-1:0]            out_data_q;
	logic                     out_ch_q;

	// shaper table read port
	logic [RA_W-1:0]          rom_addr;
	logic [SB-1:0]            rom_q;

	// delay word memory
	logic signed [STW-1:0]    mem [0:MEM_DEPTH-1];
	logic [MEM_DEPTH-1:0]     vld_q;
	logic signed [STW-1:0]    rd_data_q;
	logic                     rd_vld_q;
	logic [MA_W-1:0]          mem_raddr;
	logic [MA_W-1:0]          mem_waddr;
	logic                     mem_we;
	logic signed [STW-1:0]    mem_wdata;
	logic signed [STW-1:0]    d_word;

	logic signed [A_W-1:0]    mul_a;
	logic signed [B_W-1:0]    mul_b;
	logic signed [PRW-1:0]    p;

	logic [DRIVE_W-1:0]       dcl;
	logic [17:0]              gain;
	logic [SB-1:0]            mag;
	logic [SB-1:0]            diff;
	logic [PW-1:0]            pn;
	logic [RA_W:0]            idx_full;
	logic [SB-1:0]            tmag;
	logic signed [SB-1:0]     shaped;
	logic signed [PRW-1:0]    acc0;
	logic signed [PRW-1:0]    r8;
	logic                     in_req;
	logic                     ch_absent;

	assign in_req    = s_axis_tvalid && s_axis_tready;
	assign ch_absent = {31'b0, s_axis_tuser} >= NUM_CHANNELS;

	assign dcl  = (drive_q > DRIVE_ONE) ? DRIVE_ONE : drive_q;
	assign gain = 18'(DRIVE_ONE) + 18'(dcl) + 18'({dcl, 1'b0});
	assign mag  = x_q[SB-1] ? (~x_q + 1'b1) : x_q;
	assign diff = (rom_q > lo_q) ? (rom_q - lo_q) : '0;

	// table position: |x| * gain * entries, integer part above SH bits
	assign pn       = PW'(p[MG_W-1:0]) * PW'(NT);
	assign idx_full = pn[PW-1:SH];
	assign tmag     = end_q ? lo_q : (lo_q + p[SB+23:24]);
	assign shaped   = x_q[SB-1] ? signed'(~tmag + 1'b1) : signed'(tmag);

	assign d_word = rd_vld_q ? rd_data_q : '0;
	assign acc0   = rnd_coef(p) + PRW'(d_word);
	assign r8     = (acc0 + G_HALF) >>> GUARD_BITS;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SH_MUL: begin
				mul_a = signed'({15'b0, gain});
				mul_b = signed'({1'b0, mag});
			end
			ST_SH_DIF: begin
				mul_a = signed'({9'b0, frac_q});
				mul_b = signed'({1'b0, diff});
			end
			ST_S0: begin
				mul_a = A_W'(b0_q);
				mul_b = B_W'(x_q);
			end
			ST_S1: begin
				mul_a = A_W'(b1_q);
				mul_b = B_W'(x_q);
			end
			ST_S2: begin
				mul_a = A_W'(a1_q);
				mul_b = B_W'(y_q);
			end
			ST_S3: begin
				mul_a = A_W'(b2_q);
				mul_b = B_W'(x_q);
			end
			ST_S4: begin
				mul_a = A_W'(a2_q);
				mul_b = B_W'(y_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dbc_mul #(
		.A_W(A_W),
		.B_W(B_W)
	) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(p)
	);

	always_comb begin
		rom_addr = idx_q;
		if (state_q == ST_SH_RHI && !end_q)
			rom_addr = idx_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		rom_q <= TANH_ROM[rom_addr];
	end

	// word 0 read in S0, word 1 in S1; words written back in S3 and S5.
	// Every write lands before the next request is taken, so no forwarding.
	assign mem_raddr = MA_W'({ch_q, st_q, state_q == ST_S1});
	assign mem_waddr = MA_W'({ch_q, st_q, state_q == ST_S5});
	assign mem_we    = (state_q == ST_S3) || (state_q == ST_S5);
	assign mem_wdata = sat_st(acc_q - rnd_coef(p));

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we)
				vld_q[mem_waddr] <= 1'b1;
			rd_vld_q <= vld_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q     <= signed'(COEF_B0_RST);
			b1_q     <= '0;
			b2_q     <= '0;
			a1_q     <= '0;
			a2_q     <= '0;
			drive_q  <= '0;
			two_q    <= 1'b0;
			bypass_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_B0:     b0_q     <= signed'(cfg_wdata[COEF_W-1:0]);
				REG_B1:     b1_q     <= signed'(cfg_wdata[COEF_W-1:0]);
				REG_B2:     b2_q     <= signed'(cfg_wdata[COEF_W-1:0]);
				REG_A1:     a1_q     <= signed'(cfg_wdata[COEF_W-1:0]);
				REG_A2:     a2_q     <= signed'(cfg_wdata[COEF_W-1:0]);
				REG_DRIVE:  drive_q  <= cfg_wdata[DRIVE_W-1:0];
				REG_TWO:    two_q    <= cfg_wdata[0];
				REG_BYPASS: bypass_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			ch_q        <= 1'b0;
			st_q        <= 1'b0;
			acc_q       <= '0;
			idx_q       <= '0;
			end_q       <= 1'b0;
			frac_q      <= '0;
			lo_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_ch_q    <= 1'b0;
		end else begin
			// in DONE the output register is handled by the state arm
			if (out_valid_q && m_axis_tready && state_q != ST_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						x_q  <= signed'(s_axis_tdata[SB-1:0]);
						ch_q <= s_axis_tuser;
						st_q <= 1'b0;
						if (bypass_q || ch_absent)
							state_q <= ST_DONE;
						else if (dcl != '0)
							state_q <= ST_SH_MUL;
						else
							state_q <= ST_S0;
					end
				end
				ST_SH_MUL: state_q <= ST_SH_IDX;
				ST_SH_IDX: begin
					if (idx_full >= (RA_W + 1)'(NT)) begin
						idx_q <= RA_W'(NT);
						end_q <= 1'b1;
					end else begin
						idx_q <= idx_full[RA_W-1:0];
						end_q <= 1'b0;
					end
					frac_q  <= pn[SH-1:SH-24];
					state_q <= ST_SH_RLO;
				end
				ST_SH_RLO: state_q <= ST_SH_RHI;
				ST_SH_RHI: begin
					lo_q    <= rom_q;
					state_q <= ST_SH_DIF;
				end
				ST_SH_DIF: state_q <= ST_SH_T;
				ST_SH_T: begin
					x_q     <= shaped;
					state_q <= ST_S0;
				end
				ST_S0: state_q <= ST_S1;
				ST_S1: begin
					y_q     <= sat_y(r8);
					state_q <= ST_S2;
				end
				ST_S2: begin
					acc_q   <= rnd_coef(p) + PRW'(d_word);
					state_q <= ST_S3;
				end
				ST_S3: state_q <= ST_S4;
				ST_S4: begin
					acc_q   <= rnd_coef(p);
					state_q <= ST_S5;
				end
				ST_S5: begin
					x_q <= y_q;
					if (!st_q && two_q) begin
						st_q    <= 1'b1;
						state_q <= ST_S0;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= x_q;
						out_ch_q    <= ch_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TD_W'(out_data_q);
	assign m_axis_tuser  = out_ch_q;

`ifndef NO_ASSERTIONS
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without finishing a request");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_req |=> (state_q != ST_IDLE))
		else $error("sequencer idle right after taking a request");

	a_wr_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (({31'b0, ch_q} < NUM_CHANNELS) && !bypass_q))
		else $error("delay word write for bypass or absent channel");

	a_rom_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SH_RLO) |-> (idx_q <= RA_W'(NT)))
		else $error("tanh table index past last entry");
`endif

endmodule

>>> hdl/dbc_mul.sv
module dbc_mul #(
	parameter int A_W = 33,
	parameter int B_W = 25
) (
	input  logic                       clk,
	input  logic signed [A_W-1:0]      a,
	input  logic signed [B_W-1:0]      b,
	output logic signed [A_W+B_W-1:0]  p_q
);

	// shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

>>> bench/dbc_filter_checker.sv
`timescale 1ns / 1ps

module dbc_filter_checker #(
	parameter int NUM_CHANNELS       = dbc_pkg::DEF_NUM_CHANNELS,
	parameter int SAMPLE_BITS        = dbc_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS     = dbc_pkg::DEF_COEF_FRAC_BITS,
	parameter int TANH_TABLE_ENTRIES = dbc_pkg::DEF_TANH_TABLE_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	// [SAMPLE_BITS-1:0] sample_in, rest zero
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
	// [0] channel_in
	input  logic                                s_axis_tuser,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [SAMPLE_BITS-1:0] sample_out, rest zero
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
	// [0] channel_out
	input  logic                                m_axis_tuser,
	input  logic                                cfg_we,
	input  logic [dbc_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [dbc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output int                                  fail_count,
	output int                                  pending
);

	localparam int COEF_SH  = COEF_FRAC_BITS - dbc_pkg::GUARD_BITS;
	localparam int STATE_W  = SAMPLE_BITS + 16;
	localparam int SHAPE_SH = SAMPLE_BITS + 16;
	localparam longint unsigned Q30 = 64'd1 << 30;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smp;
		logic                   ch;
	} filt_result_t;

	filt_result_t filtered_q[$];

	longint unsigned tanh_lut [0:TANH_TABLE_ENTRIES];

	longint b0, b1, b2, a1, a2;
	logic [dbc_pkg::DRIVE_W-1:0] drive;
	logic two_sec;
	logic bypass;
	// delay words per channel, section, word; units of sample LSB / 2^GUARD_BITS
	longint dly [0:NUM_CHANNELS-1][0:1][0:1];

	// e^-a in Q30 by a series up to the a^12 term
	function automatic longint unsigned exp_neg(input longint unsigned a);
		longint acc;
		longint unsigned term;
		acc = longint'(Q30);
		term = Q30;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * a) >> 30) / k;
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		return (acc > 0) ? $unsigned(acc) : 64'd0;
	endfunction

	function automatic longint unsigned tanh_point(input int idx);
		longint unsigned e;
		longint unsigned num;
		longint unsigned den;
		e = exp_neg((longint'(idx) << 29) / TANH_TABLE_ENTRIES);
		// e^-(a*16) = e^-(2x) for x = 4*idx/N
		repeat (4) e = (e * e + (64'd1 << 29)) >> 30;
		if (e > Q30)
			e = Q30;
		num = Q30 - e;
		den = Q30 + e;
		return ((num << (SAMPLE_BITS - 1)) + den / 2) / den;
	endfunction

	initial begin
		for (int i = 0; i <= TANH_TABLE_ENTRIES; i++)
			tanh_lut[i] = tanh_point(i);
	end

	function automatic longint saturate_tanh(input longint x, input longint unsigned gain);
		longint unsigned mag;
		longint unsigned p;
		longint unsigned idx;
		longint unsigned frac;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned diff;
		longint unsigned t;
		mag = (x < 0) ? $unsigned(-x) : $unsigned(x);
		p = mag * gain * TANH_TABLE_ENTRIES;
		idx = p >> SHAPE_SH;
		if (idx >= TANH_TABLE_ENTRIES) begin
			t = tanh_lut[TANH_TABLE_ENTRIES];
		end else begin
			frac = (p & ((64'd1 << SHAPE_SH) - 1)) >> (SHAPE_SH - 24);
			lo = tanh_lut[idx];
			hi = tanh_lut[idx + 1];
			diff = (hi > lo) ? hi - lo : 64'd0;
			t = lo + ((diff * frac) >> 24);
		end
		return (x < 0) ? -longint'(t) : longint'(t);
	endfunction

	// round half up, floor semantics for negatives
	function automatic longint rnd_shr(input longint v, input int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		hi = (longint'(1) << (bits - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	function automatic longint run_section(input int ch, input int st, input longint x);
		longint y;
		longint s1;
		longint s2;
		y = clip(rnd_shr(rnd_shr(b0 * x, COEF_SH) + dly[ch][st][0], dbc_pkg::GUARD_BITS),
			SAMPLE_BITS);
		s1 = rnd_shr(b1 * x, COEF_SH) - rnd_shr(a1 * y, COEF_SH) + dly[ch][st][1];
		s2 = rnd_shr(b2 * x, COEF_SH) - rnd_shr(a2 * y, COEF_SH);
		dly[ch][st][0] = clip(s1, STATE_W);
		dly[ch][st][1] = clip(s2, STATE_W);
		return y;
	endfunction

	function automatic filt_result_t filter_sample(input logic [SAMPLE_BITS-1:0] raw,
			input logic ch);
		longint x;
		longint unsigned drv;
		filt_result_t r;
		x = longint'($signed(raw));
		if (!bypass && int'(ch) < NUM_CHANNELS) begin
			drv = (drive > dbc_pkg::DRIVE_ONE) ? dbc_pkg::DRIVE_ONE : drive;
			if (drv != 0)
				x = saturate_tanh(x, longint'(dbc_pkg::DRIVE_ONE) + 3 * drv);
			x = run_section(ch, 0, x);
			if (two_sec)
				x = run_section(ch, 1, x);
		end
		r.smp = x[SAMPLE_BITS-1:0];
		r.ch = ch;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filt_result_t got;
		filt_result_t want;
		if (!arst_n) begin
			b0 = longint'($signed(dbc_pkg::COEF_B0_RST));
			b1 = 0;
			b2 = 0;
			a1 = 0;
			a2 = 0;
			drive = '0;
			two_sec = 1'b0;
			bypass = 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++)
				for (int s = 0; s < 2; s++)
					for (int w = 0; w < 2; w++)
						dly[c][s][w] = 0;
			filtered_q.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.smp = m_axis_tdata[SAMPLE_BITS-1:0];
				got.ch = m_axis_tuser;
				if (filtered_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with none expected: sample %0d channel %0d",
						$time, $signed(got.smp), got.ch);
				end else begin
					want = filtered_q.pop_front();
					if (got.smp !== want.smp || got.ch !== want.ch) begin
						fail_count++;
						$display("%0t: sample expected %0d got %0d, channel expected %0d got %0d",
							$time, $signed(want.smp), $signed(got.smp), want.ch, got.ch);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					dbc_pkg::REG_B0:     b0 = longint'($signed(cfg_wdata));
					dbc_pkg::REG_B1:     b1 = longint'($signed(cfg_wdata));
					dbc_pkg::REG_B2:     b2 = longint'($signed(cfg_wdata));
					dbc_pkg::REG_A1:     a1 = longint'($signed(cfg_wdata));
					dbc_pkg::REG_A2:     a2 = longint'($signed(cfg_wdata));
					dbc_pkg::REG_DRIVE:  drive = cfg_wdata[dbc_pkg::DRIVE_W-1:0];
					dbc_pkg::REG_TWO:    two_sec = cfg_wdata[0];
					dbc_pkg::REG_BYPASS: bypass = cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				filtered_q.push_back(filter_sample(s_axis_tdata[SAMPLE_BITS-1:0], s_axis_tuser));
			pending = filtered_q.size();
		end
	end

endmodule

>>> bench/drive_biquad_cascade_unit_tb.sv
`timescale 1ns / 1ps

module drive_biquad_cascade_unit_tb;

	localparam int SB          = dbc_pkg::DEF_SAMPLE_BITS;
	localparam int DATA_W      = ((SB+7)/8)*8;
	localparam int LIMIT       = 300000;
	localparam int SETTLE      = 40;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_ITEMS = 85;

	localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
	localparam logic [SB-1:0] S_NEG1 = {SB{1'b1}};
	localparam logic [SB-1:0] S_ONE = SB'(1);

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [DATA_W-1:0]                  s_axis_tdata = '0;
	logic                               s_axis_tuser = 1'b0;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic [DATA_W-1:0]                  m_axis_tdata;
	logic                               m_axis_tuser;
	logic                               cfg_we = 1'b0;
	logic [dbc_pkg::CFG_IDX_W-1:0]      cfg_idx = '0;
	logic [dbc_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

	int fail_count;
	int pending;
	int cycle_cnt = 0;
	bit calm = 1'b0;
	int gap_odds = 4;
	int stall_odds = 8;

	drive_biquad_cascade_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata)
	);

	dbc_filter_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("** drive_biquad_cascade_unit: FAILED **");
			$finish;
		end
	end

	// output side back-pressure in random bursts
	initial begin
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(1, stall_odds) == 1) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_sample(input logic [SB-1:0] smp, input logic ch);
		if (!calm && $urandom_range(1, gap_odds) == 1) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= DATA_W'(smp);
		s_axis_tuser <= ch;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [dbc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic load_setup(input logic [31:0] b0, input logic [31:0] b1,
			input logic [31:0] b2, input logic [31:0] a1, input logic [31:0] a2,
			input logic [15:0] drv, input logic two, input logic byp);
		write_reg(dbc_pkg::REG_B0, b0);
		write_reg(dbc_pkg::REG_B1, b1);
		write_reg(dbc_pkg::REG_B2, b2);
		write_reg(dbc_pkg::REG_A1, a1);
		write_reg(dbc_pkg::REG_A2, a2);
		write_reg(dbc_pkg::REG_DRIVE, {16'd0, drv});
		write_reg(dbc_pkg::REG_TWO, {31'd0, two});
		write_reg(dbc_pkg::REG_BYPASS, {31'd0, byp});
		cfg_we <= 1'b0;
	endtask

	// wait until every request has its result, then let the pipeline go quiet
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [SB-1:0] rand_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return r[SB-1:0];
			5, 6: return {{(SB-12){r[11]}}, r[11:0]};
			7: return r[0] ? S_MAX : S_MIN;
			8: return r[0] ? S_MAX - SB'(r[9:1]) : S_MIN + SB'(r[9:1]);
			default: begin
				case (r[1:0])
					2'd0: return '0;
					2'd1: return S_ONE;
					default: return S_NEG1;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_coef(input bit wild, input int unsigned span);
		if (wild)
			return $urandom;
		return $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic logic [15:0] rand_drive();
		case ($urandom_range(0, 4))
			0, 1: return 16'd0;
			2: return 16'($urandom_range(1, 32768));
			3: return dbc_pkg::DRIVE_ONE;
			default: return 16'($urandom_range(32769, 65535));
		endcase
	endfunction

	initial begin
		bit wild;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults after reset: unity b0, one section
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b1);
		send_sample('0, 1'b0);
		send_sample(S_NEG1, 1'b1);
		send_sample(S_ONE, 1'b0);
		drain();

		// bypass
		load_setup(dbc_pkg::COEF_B0_RST, '0, '0, '0, '0, 16'd0, 1'b0, 1'b1);
		send_sample(S_MAX, 1'b1);
		send_sample(S_MIN, 1'b0);
		drain();

		// coefficient extremes, drive above one, two sections, table end
		load_setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			16'hFFFF, 1'b1, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_ONE, 1'b1);
		send_sample(S_NEG1, 1'b1);
		send_sample(S_MAX, 1'b1);
		send_sample(SB'(24'h000100), 1'b0);
		drain();

		// most negative b0, full drive
		load_setup(32'h8000_0000, '0, '0, '0, '0, dbc_pkg::DRIVE_ONE, 1'b0, 1'b0);
		send_sample(SB'(24'h400000), 1'b0);
		send_sample(SB'(24'hC00000), 1'b1);
		send_sample(S_MIN, 1'b0);
		drain();

		// smallest nonzero drive, strong feedback with a1 at -2.0
		load_setup(dbc_pkg::COEF_B0_RST, 32'h0800_0000, 32'h0400_0000, 32'hE000_0000,
			32'h0400_0000, 16'd1, 1'b1, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(SB'(24'h123456), 1'b1);
		send_sample(SB'(24'hFEDCBA), 1'b0);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wild = ($urandom_range(0, 3) == 0);
			// tame spans: b about +-1.0, a1 about +-1.8, a2 about +-0.9
			load_setup(rand_coef(wild, 268435456), rand_coef(wild, 268435456),
				rand_coef(wild, 268435456), rand_coef(wild, 483183820),
				rand_coef(wild, 241591910), rand_drive(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 5) == 0));
			calm = (ph == RAND_PHASES - 1);
			gap_odds = $urandom_range(2, 12);
			stall_odds = $urandom_range(2, 12);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(rand_sample(), 1'($urandom_range(0, 1)));
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("** drive_biquad_cascade_unit: PASSED **");
		else
			$display("** drive_biquad_cascade_unit: FAILED **");
		$finish;
	end

endmodule
